/* rtl/core/http_chunked_body_decoder_defines.svh */
// assertion macros for the chunked body decoder
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// same-cycle implication
`define HCBD_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HCBD_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/hcbd_pkg.sv */
package hcbd_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int LINE_KEEP_DEF  = 39;
	localparam int RADIX_BITS     = 4;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	typedef enum logic [1:0] {
		PH_SIZE = 2'd0,
		PH_DATA = 2'd1,
		PH_SKIP = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		NUM_BLANK  = 3'd0,
		NUM_ZERO   = 3'd1,
		NUM_PREFIX = 3'd2,
		NUM_DIGITS = 3'd3,
		NUM_ENDED  = 3'd4
	} num_stage_t;

	typedef struct packed {
		logic                  valid;
		logic [RADIX_BITS-1:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t h;
		h.valid = 1'b0;
		h.value = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.valid = 1'b1;
			h.value = RADIX_BITS'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.valid = 1'b1;
			h.value = RADIX_BITS'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.valid = 1'b1;
			h.value = RADIX_BITS'(c - 8'h37);
		end
		return h;
	endfunction

endpackage

/* rtl/core/http_chunked_body_decoder.sv */
// http chunked body decoder
// s_axis: one raw byte of a chunk-encoded body per transaction (tdata[7:0])
// m_axis: one result per payload byte (tdata = byte, tlast = 0), plus one
//   end marker (tdata = 0, tlast = 1) once the zero-size chunk line ends
// size lines, their hex parsing and trailing line text produce no output
// a payload byte or the end marker appears on m_axis in the cycle after its
//   input transaction
// throughput: one byte per cycle while s_axis_tready is high, set by the single
//   state update per byte between the input port and the output register
// s_axis_tready is high whenever the output register is empty or is being
//   taken in the same cycle; a stalled receiver stalls the input after one
//   result is held
// after the end marker every further byte is taken and dropped until reset
// reset (arst_n low) returns to the size-line phase with an empty output
module http_chunked_body_decoder #(
	parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF,
	parameter int LINE_KEEP  = hcbd_pkg::LINE_KEEP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // rx_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // data_byte
	output logic       m_axis_tlast    // end_of_body
);
	import hcbd_pkg::*;

	`include "http_chunked_body_decoder_defines.svh"

	localparam int LC_W = $clog2(LINE_KEEP + 1);

	phase_t                  phase_q, phase_d;
	num_stage_t              stage_q, stage_d;
	logic [COUNT_BITS-1:0]   bytes_left_q, bytes_left_d;
	logic [COUNT_BITS-1:0]   accum_q, accum_d;
	logic [LC_W-1:0]         line_count_q, line_count_d;
	logic                    out_valid_q;
	logic [7:0]              out_data_q;
	logic                    out_last_q;

	logic                    accept;
	logic                    emit;
	logic                    emit_last;
	logic [7:0]              c;
	hex_digit_t              hd;
	logic                    sat;
	logic [COUNT_BITS-1:0]   accum_dig;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign c             = s_axis_tdata;
	assign hd            = hex_decode(c);

	// saturate when any of the top digit bits would shift out
	assign sat       = |accum_q[COUNT_BITS-1 -: RADIX_BITS];
	assign accum_dig = sat ? {COUNT_BITS{1'b1}}
	                       : {accum_q[COUNT_BITS-RADIX_BITS-1:0], hd.value};

	always_comb begin
		phase_d      = phase_q;
		stage_d      = stage_q;
		bytes_left_d = bytes_left_q;
		accum_d      = accum_q;
		line_count_d = line_count_q;
		emit         = 1'b0;
		emit_last    = 1'b0;
		if (accept) begin
			case (phase_q)
				PH_SIZE: begin
					if (c == CH_LF) begin
						bytes_left_d = accum_q;
						accum_d      = '0;
						line_count_d = '0;
						stage_d      = NUM_BLANK;
						if (accum_q == '0) begin
							phase_d   = PH_DONE;
							emit      = 1'b1;
							emit_last = 1'b1;
						end else begin
							phase_d = PH_DATA;
						end
					end else if (line_count_q < LC_W'(LINE_KEEP)) begin
						line_count_d = line_count_q + LC_W'(1);
						case (stage_q)
							NUM_BLANK: begin
								if (c != CH_SPACE && c != CH_TAB) begin
									if (!hd.valid) begin
										stage_d = NUM_ENDED;
									end else begin
										accum_d = accum_dig;
										stage_d = (hd.value == '0) ? NUM_ZERO : NUM_DIGITS;
									end
								end
							end
							NUM_ZERO: begin
								if (c == CH_X_LO || c == CH_X_UP) begin
									stage_d = NUM_PREFIX;
								end else if (!hd.valid) begin
									stage_d = NUM_ENDED;
								end else begin
									accum_d = accum_dig;
									stage_d = NUM_DIGITS;
								end
							end
							NUM_PREFIX, NUM_DIGITS: begin
								if (!hd.valid) begin
									stage_d = NUM_ENDED;
								end else begin
									accum_d = accum_dig;
									stage_d = NUM_DIGITS;
								end
							end
							default: begin
								stage_d = stage_q;
							end
						endcase
					end
				end
				PH_DATA: begin
					emit         = 1'b1;
					bytes_left_d = bytes_left_q - COUNT_BITS'(1);
					if (bytes_left_q == COUNT_BITS'(1)) begin
						phase_d = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (c == CH_LF) begin
						phase_d = PH_SIZE;
					end
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SIZE;
			stage_q      <= NUM_BLANK;
			bytes_left_q <= '0;
			accum_q      <= '0;
			line_count_q <= '0;
		end else begin
			phase_q      <= phase_d;
			stage_q      <= stage_d;
			bytes_left_q <= bytes_left_d;
			accum_q      <= accum_d;
			line_count_q <= line_count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= emit_last ? 8'h00 : c;
			out_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	`HCBD_ASSERT_NXT(a_done_sticky, phase_q == PH_DONE, phase_q == PH_DONE, "left done phase")
	`HCBD_ASSERT_IMP(a_data_nonzero, phase_q == PH_DATA, bytes_left_q != '0, "data with no count")
	`HCBD_ASSERT_IMP(a_line_bound, 1'b1, line_count_q <= LC_W'(LINE_KEEP), "line count overrun")
	`HCBD_ASSERT_IMP(a_end_zero, m_axis_tvalid && m_axis_tlast, m_axis_tdata == 8'h00,
		"end marker carries data")

endmodule
